[hw/rtl/wfdc_pkg.sv]
// ----------------------------------------------------------------------------
// wfdc_pkg: shared types and constants of the wall-following drive controller
// Widths, register indexes, segment kinds, the control/result bundle and the
// wheel clamp used by the controller and its pipeline.
// ----------------------------------------------------------------------------
package wfdc_pkg;

   localparam int WALL_BITS      = 12;
   localparam int WHEEL_BITS     = 10;
   localparam int SPEED_BITS     = 9;
   localparam int TICK_BITS      = 7;
   localparam int TARGET_BITS    = 12;
   localparam int PTIMER_BITS    = 16;
   localparam int STIMER_BITS    = 32;
   localparam int SEG_LEN_BITS   = 16;
   localparam int KIND_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;

   // signed width that holds cruise speed plus or minus the steering term
   localparam int SUM_BITS = ((WALL_BITS > SPEED_BITS) ? WALL_BITS : SPEED_BITS) + 2;

   localparam int REQ_TDATA_BITS = ((WALL_BITS + 2 + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = 40;
   localparam int RSP_TUSER_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRUISE_SPEED        = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPIN_SPEED          = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_MS             = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_WALL_TARGET = 2'd3;

   localparam logic [SPEED_BITS-1:0]  CRUISE_SPEED_RESET = 9'd150;
   localparam logic [SPEED_BITS-1:0]  SPIN_SPEED_RESET   = 9'd80;
   localparam logic [TICK_BITS-1:0]   TICK_MS_RESET      = 7'd5;
   localparam logic [TARGET_BITS-1:0] WALL_TARGET_RESET  = 12'd80;

   localparam logic [KIND_BITS-1:0] SEG_LEFT_TURN  = 2'd0;
   localparam logic [KIND_BITS-1:0] SEG_RIGHT_TURN = 2'd1;
   localparam logic [KIND_BITS-1:0] SEG_STOP       = 2'd2;

   localparam logic signed [WHEEL_BITS-1:0] WHEEL_LIMIT = 10'sd500;

   typedef struct packed {
      logic [SPEED_BITS-1:0]  cruise_speed;
      logic [SPEED_BITS-1:0]  spin_speed;
      logic [TICK_BITS-1:0]   tick_ms;
      logic [TARGET_BITS-1:0] initial_wall_target;
   } wfdc_cfg_type;

   typedef struct packed {
      logic signed [WHEEL_BITS-1:0] left_wheel_speed;
      logic signed [WHEEL_BITS-1:0] right_wheel_speed;
      logic                         segment_valid;
      logic [KIND_BITS-1:0]         segment_kind;
      logic                         run_finished;
   } wfdc_result_type;

   function automatic logic signed [WHEEL_BITS-1:0] clamp_wheel(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0]   lim;
      logic signed [WHEEL_BITS-1:0] r;
      lim = SUM_BITS'(WHEEL_LIMIT);
      if (v > lim) begin
         r = WHEEL_LIMIT;
      end else if (v < -lim) begin
         r = -WHEEL_LIMIT;
      end else begin
         r = v[WHEEL_BITS-1:0];
      end
      return r;
   endfunction

endpackage

[hw/rtl/wfdc_ctrl.sv]
// ----------------------------------------------------------------------------
// wfdc_ctrl: drive sequencer
// Holds the run state and works out one tick per accepted beat: timers,
// phase changes, wall target tracking, steering and the segment report.
// ----------------------------------------------------------------------------
module wfdc_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             stop,
   input  logic                             bump,
   input  logic [wfdc_pkg::WALL_BITS-1:0]   wall,
   input  wfdc_pkg::wfdc_cfg_type           cfg,
   input  logic                             target_load,
   input  logic [wfdc_pkg::TARGET_BITS-1:0] target_value,
   output wfdc_pkg::wfdc_result_type        result,
   output logic [wfdc_pkg::STIMER_BITS-1:0] seg_timer
);

   localparam int W  = wfdc_pkg::WALL_BITS;
   localparam int SB = wfdc_pkg::SUM_BITS;
   localparam int PB = wfdc_pkg::PTIMER_BITS;
   localparam int TB = wfdc_pkg::STIMER_BITS;
   localparam int WB = wfdc_pkg::WHEEL_BITS;

   localparam logic [3:0] PH_FWD    = 4'd0;
   localparam logic [3:0] PH_CAL_A  = 4'd1;
   localparam logic [3:0] PH_CAL_B  = 4'd2;
   localparam logic [3:0] PH_PEAK   = 4'd3;
   localparam logic [3:0] PH_ALIGN  = 4'd4;
   localparam logic [3:0] PH_FOLLOW = 4'd5;
   localparam logic [3:0] PH_LTURN  = 4'd6;
   localparam logic [3:0] PH_LRECOV = 4'd7;
   localparam logic [3:0] PH_RTURN  = 4'd8;

   localparam logic [1:0] RT_WAIT  = 2'd0;
   localparam logic [1:0] RT_SPIN  = 2'd1;
   localparam logic [1:0] RT_DRIVE = 2'd2;

   localparam logic [W-1:0] LVL_DARK  = W'(10);
   localparam logic [W-1:0] LVL_SEEN  = W'(20);
   localparam logic [W-1:0] LVL_LOST  = W'(5);

   localparam logic [PB-1:0] LTURN_TIMEOUT = PB'(5000);
   localparam logic [PB-1:0] RECOVER_TIME  = PB'(2500);
   localparam logic [PB-1:0] RT_WAIT_TIME  = PB'(2000);
   localparam logic [PB-1:0] RT_SPIN_TIME  = PB'(2500);
   localparam logic [PB-1:0] RT_DRIVE_TIME = PB'(2200);

   // floor(x / 3) = (x * DIV3_MUL) >> (W + 2) for x below 2**W
   localparam logic [W:0] DIV3_MUL = (W+1)'((2**(W+2) + 2) / 3);

   logic [3:0]        phase_ff, phase_in;
   logic [W-1:0]      target_ff, target_in;
   logic [PB-1:0]     ptimer_ff, ptimer_in;
   logic [TB-1:0]     stimer_ff, stimer_in;
   logic [1:0]        rt_step_ff, rt_step_in;
   logic signed [WB-1:0] left_ff, left_in, right_ff, right_in;
   logic              finished_ff, finished_in;

   logic [PB:0]       ptimer_sum;
   logic [TB:0]       stimer_sum;
   logic [PB-1:0]     ptimer_adv;
   logic [TB-1:0]     stimer_adv;

   logic [W-1:0]      err_mag;
   logic              err_neg;
   logic [2*W:0]      err_prod;
   logic [SB-1:0]     err_quot;
   logic signed [SB-1:0] diff;
   logic signed [SB-1:0] cs_s, ss_s;
   logic [W+1:0]      target_x3;
   logic [W:0]        turn_level;

   logic              seg_valid;
   logic [wfdc_pkg::KIND_BITS-1:0] seg_kind;

   assign ptimer_sum = {1'b0, ptimer_ff} + (PB+1)'(cfg.tick_ms);
   assign stimer_sum = {1'b0, stimer_ff} + (TB+1)'(cfg.tick_ms);
   assign ptimer_adv = ptimer_sum[PB] ? {PB{1'b1}} : ptimer_sum[PB-1:0];
   assign stimer_adv = stimer_sum[TB] ? {TB{1'b1}} : stimer_sum[TB-1:0];

   assign err_neg  = wall > target_ff;
   assign err_mag  = err_neg ? (wall - target_ff) : (target_ff - wall);
   assign err_prod = (2*W+1)'(err_mag) * (2*W+1)'(DIV3_MUL);
   assign err_quot = SB'(err_prod[2*W:W+2]);
   assign diff     = err_neg ? -$signed(err_quot) : $signed(err_quot);

   assign cs_s = $signed(SB'(cfg.cruise_speed));
   assign ss_s = $signed(SB'(cfg.spin_speed));

   assign target_x3  = {1'b0, target_ff, 1'b0} + {2'b00, target_ff};
   assign turn_level = target_x3[W+1:1];

   always_comb begin
      phase_in    = phase_ff;
      target_in   = target_ff;
      ptimer_in   = ptimer_ff;
      stimer_in   = stimer_ff;
      rt_step_in  = rt_step_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      finished_in = finished_ff;
      seg_valid   = 1'b0;
      seg_kind    = wfdc_pkg::SEG_LEFT_TURN;
      if (accept) begin
         if (finished_ff) begin
            left_in  = '0;
            right_in = '0;
         end else begin
            ptimer_in = ptimer_adv;
            stimer_in = stimer_adv;
            if (stop) begin
               seg_valid   = 1'b1;
               seg_kind    = wfdc_pkg::SEG_STOP;
               left_in     = '0;
               right_in    = '0;
               finished_in = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_FWD: begin
                     if (bump) begin
                        left_in  = wfdc_pkg::clamp_wheel(-ss_s);
                        right_in = wfdc_pkg::clamp_wheel(ss_s);
                        phase_in = PH_CAL_A;
                     end else begin
                        left_in  = wfdc_pkg::clamp_wheel(cs_s);
                        right_in = wfdc_pkg::clamp_wheel(cs_s);
                     end
                  end
                  PH_CAL_A: begin
                     if (wall <= LVL_DARK) phase_in = PH_CAL_B;
                  end
                  PH_CAL_B: begin
                     if (wall >= LVL_SEEN) phase_in = PH_PEAK;
                  end
                  PH_PEAK: begin
                     if (wall > target_ff) begin
                        target_in = wall;
                     end else if (wall < LVL_LOST) begin
                        left_in   = wfdc_pkg::clamp_wheel(ss_s);
                        right_in  = wfdc_pkg::clamp_wheel(-ss_s);
                        target_in = target_ff >> 1;
                        phase_in  = PH_ALIGN;
                     end
                  end
                  PH_ALIGN: begin
                     if (wall > target_ff) begin
                        left_in  = '0;
                        right_in = '0;
                        phase_in = PH_FOLLOW;
                     end
                  end
                  PH_FOLLOW: begin
                     if (bump) begin
                        seg_valid = 1'b1;
                        seg_kind  = wfdc_pkg::SEG_LEFT_TURN;
                        left_in   = wfdc_pkg::clamp_wheel(-ss_s);
                        right_in  = wfdc_pkg::clamp_wheel(ss_s);
                        ptimer_in = '0;
                        phase_in  = PH_LTURN;
                     end else if (wall < LVL_LOST) begin
                        left_in    = wfdc_pkg::clamp_wheel(cs_s);
                        right_in   = wfdc_pkg::clamp_wheel(cs_s);
                        ptimer_in  = '0;
                        rt_step_in = RT_WAIT;
                        phase_in   = PH_RTURN;
                     end else begin
                        left_in  = wfdc_pkg::clamp_wheel(cs_s + diff);
                        right_in = wfdc_pkg::clamp_wheel(cs_s - diff);
                     end
                  end
                  PH_LTURN: begin
                     if ({1'b0, wall} > turn_level) begin
                        left_in   = '0;
                        right_in  = '0;
                        stimer_in = '0;
                        phase_in  = PH_FOLLOW;
                     end else if (ptimer_adv > LTURN_TIMEOUT) begin
                        left_in   = wfdc_pkg::clamp_wheel(ss_s);
                        right_in  = wfdc_pkg::clamp_wheel(-ss_s);
                        ptimer_in = '0;
                        phase_in  = PH_LRECOV;
                     end
                  end
                  PH_LRECOV: begin
                     if (ptimer_adv >= RECOVER_TIME) begin
                        left_in   = '0;
                        right_in  = '0;
                        stimer_in = '0;
                        phase_in  = PH_FOLLOW;
                     end
                  end
                  PH_RTURN: begin
                     if ((wall > LVL_LOST && rt_step_ff != RT_SPIN) || bump) begin
                        phase_in = PH_FOLLOW;
                     end else if (rt_step_ff == RT_WAIT && ptimer_adv > RT_WAIT_TIME) begin
                        left_in    = wfdc_pkg::clamp_wheel(ss_s);
                        right_in   = wfdc_pkg::clamp_wheel(-ss_s);
                        ptimer_in  = '0;
                        seg_valid  = 1'b1;
                        seg_kind   = wfdc_pkg::SEG_RIGHT_TURN;
                        rt_step_in = RT_SPIN;
                     end else if (rt_step_ff == RT_SPIN && ptimer_adv > RT_SPIN_TIME) begin
                        left_in    = wfdc_pkg::clamp_wheel(cs_s);
                        right_in   = wfdc_pkg::clamp_wheel(cs_s);
                        ptimer_in  = '0;
                        stimer_in  = '0;
                        rt_step_in = RT_DRIVE;
                     end else if (rt_step_ff == RT_DRIVE && ptimer_adv > RT_DRIVE_TIME) begin
                        phase_in = PH_FOLLOW;
                     end
                  end
                  default: begin
                     phase_in = PH_FOLLOW;
                  end
               endcase
            end
         end
      end else if (target_load && phase_ff < PH_PEAK) begin
         target_in = W'(target_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FWD;
         target_ff   <= W'(wfdc_pkg::WALL_TARGET_RESET);
         ptimer_ff   <= '0;
         stimer_ff   <= '0;
         rt_step_ff  <= RT_WAIT;
         left_ff     <= '0;
         right_ff    <= '0;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         target_ff   <= target_in;
         ptimer_ff   <= ptimer_in;
         stimer_ff   <= stimer_in;
         rt_step_ff  <= rt_step_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
         finished_ff <= finished_in;
      end
   end

   assign result.left_wheel_speed  = left_in;
   assign result.right_wheel_speed = right_in;
   assign result.segment_valid     = seg_valid;
   assign result.segment_kind      = seg_kind;
   assign result.run_finished      = finished_in;
   assign seg_timer                = stimer_adv;

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("run left the finished state without reset");

   a_stop_finishes: assert property (@(posedge clock) disable iff (reset)
      (accept && stop) |=> (finished_ff && left_ff == '0 && right_ff == '0))
      else $error("stop beat did not park the wheels");

endmodule

[hw/rtl/wfdc_seglen.sv]
// ----------------------------------------------------------------------------
// wfdc_seglen: segment length pipeline
// Multiplies elapsed time by cruise speed, then divides by 8000 through a
// reciprocal multiply, saturating at the top of the 16-bit range.
// ----------------------------------------------------------------------------
module wfdc_seglen (
   input  logic                              clock,
   input  logic                              en_product,
   input  logic                              en_length,
   input  logic                              seg_valid,
   input  logic [wfdc_pkg::STIMER_BITS-1:0]  seg_timer,
   input  logic [wfdc_pkg::SPEED_BITS-1:0]   cruise_speed,
   output logic [wfdc_pkg::SEG_LEN_BITS-1:0] seg_length
);

   localparam int PRODUCT_BITS = wfdc_pkg::STIMER_BITS + wfdc_pkg::SPEED_BITS;
   localparam int LB           = wfdc_pkg::SEG_LEN_BITS;
   // 8000 = 64 * 125; the shifted product stays below 2**23 when not saturated
   localparam int DIV_SHIFT    = 6;
   localparam int X_BITS       = 23;
   localparam int RECIP_SHIFT  = 30;
   localparam int RECIP_BITS   = 24;
   localparam int QPROD_BITS   = X_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_125 = RECIP_BITS'(((2**RECIP_SHIFT) + 124) / 125);
   localparam logic [PRODUCT_BITS-1:0] SAT_PRODUCT = PRODUCT_BITS'(64'd65536 * 64'd8000);

   logic [PRODUCT_BITS-1:0] product_ff, product_in;
   logic                    valid_ff;
   logic [LB-1:0]           length_ff, length_in;
   logic [X_BITS-1:0]       x;
   logic [QPROD_BITS-1:0]   qprod;

   assign product_in = PRODUCT_BITS'(seg_timer) * PRODUCT_BITS'(cruise_speed);

   assign x     = product_ff[DIV_SHIFT+X_BITS-1:DIV_SHIFT];
   assign qprod = QPROD_BITS'(x) * QPROD_BITS'(RECIP_125);

   always_comb begin
      if (!valid_ff) begin
         length_in = '0;
      end else if (product_ff >= SAT_PRODUCT) begin
         length_in = {LB{1'b1}};
      end else begin
         length_in = qprod[RECIP_SHIFT+LB-1:RECIP_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (en_product) begin
         product_ff <= product_in;
         valid_ff   <= seg_valid;
      end
      if (en_length) begin
         length_ff <= length_in;
      end
   end

   assign seg_length = length_ff;

endmodule

[hw/rtl/wall_following_drive_controller.sv]
// ----------------------------------------------------------------------------
// wall_following_drive_controller: wall-following drive sequencer
// One sensor tick in, one wheel command (with optional segment report) out.
// ----------------------------------------------------------------------------
// Takes one tick beat per clock while it has room, and returns exactly one
// result beat per tick. The beat passes the sequencer stage, the time-by-speed
// product stage and the output register; the first of these loads at the
// accepting edge itself, and rsp_tvalid rises when the beat reaches the output
// register. The run state advances at the accepting edge, so back-to-back ticks
// need no gaps; req_tready drops only when all three stages hold beats that the
// result side has not taken. Registers are to be written through csr_* only
// between runs of ticks, once the last result has been taken; the block does
// not enforce this. A tick with req_tlast high is the stop request.
module wall_following_drive_controller (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [wfdc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [wfdc_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // bump_left, bump_right, wall_level, zero fill
   input  logic [wfdc_pkg::REQ_TDATA_BITS-1:0]    req_tdata,
   // stop_request
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // left_wheel_speed, right_wheel_speed, segment_length, run_finished, zero fill
   output logic [wfdc_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,
   // segment_valid, segment_kind
   output logic [wfdc_pkg::RSP_TUSER_BITS-1:0]    rsp_tuser
);

   localparam int W  = wfdc_pkg::WALL_BITS;
   localparam int LB = wfdc_pkg::SEG_LEN_BITS;
   localparam int WB = wfdc_pkg::WHEEL_BITS;
   localparam int RSP_USED = 2 * WB + LB + 1;

   wfdc_pkg::wfdc_cfg_type    cfg_ff;
   wfdc_pkg::wfdc_result_type ctrl_result, s1_ff, s2_ff, rsp_ff;
   logic [wfdc_pkg::STIMER_BITS-1:0] ctrl_timer, s1_timer_ff;
   logic [LB-1:0]                    seg_length;

   logic v1_ff, v1_in, v2_ff, v2_in, rsp_valid_ff, rsp_valid_in;
   logic en1, en2, en3, accept, target_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cruise_speed        <= wfdc_pkg::CRUISE_SPEED_RESET;
         cfg_ff.spin_speed          <= wfdc_pkg::SPIN_SPEED_RESET;
         cfg_ff.tick_ms             <= wfdc_pkg::TICK_MS_RESET;
         cfg_ff.initial_wall_target <= wfdc_pkg::WALL_TARGET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wfdc_pkg::CSR_CRUISE_SPEED:
               cfg_ff.cruise_speed <= csr_wdata[wfdc_pkg::SPEED_BITS-1:0];
            wfdc_pkg::CSR_SPIN_SPEED:
               cfg_ff.spin_speed <= csr_wdata[wfdc_pkg::SPEED_BITS-1:0];
            wfdc_pkg::CSR_TICK_MS:
               cfg_ff.tick_ms <= csr_wdata[wfdc_pkg::TICK_BITS-1:0];
            wfdc_pkg::CSR_INITIAL_WALL_TARGET:
               cfg_ff.initial_wall_target <= csr_wdata[wfdc_pkg::TARGET_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign target_load = csr_we && (csr_index == wfdc_pkg::CSR_INITIAL_WALL_TARGET);

   // advance a stage when the one after it is empty or moving
   assign en3        = !rsp_valid_ff || rsp_tready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;
   assign accept     = req_tvalid && en1;

   assign v1_in        = en1 ? req_tvalid : v1_ff;
   assign v2_in        = en2 ? v1_ff : v2_ff;
   assign rsp_valid_in = en3 ? v2_ff : rsp_valid_ff;

   wfdc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stop         (req_tlast),
      .bump         (req_tdata[0] | req_tdata[1]),
      .wall         (req_tdata[W+1:2]),
      .cfg          (cfg_ff),
      .target_load  (target_load),
      .target_value (csr_wdata[wfdc_pkg::TARGET_BITS-1:0]),
      .result       (ctrl_result),
      .seg_timer    (ctrl_timer)
   );

   wfdc_seglen u_seglen (
      .clock        (clock),
      .en_product   (en2),
      .en_length    (en3),
      .seg_valid    (s1_ff.segment_valid),
      .seg_timer    (s1_timer_ff),
      .cruise_speed (cfg_ff.cruise_speed),
      .seg_length   (seg_length)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_ff       <= ctrl_result;
         s1_timer_ff <= ctrl_timer;
      end
      if (en2) begin
         s2_ff <= s1_ff;
      end
      if (en3) begin
         rsp_ff <= s2_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(wfdc_pkg::RSP_TDATA_BITS - RSP_USED){1'b0}},
                        rsp_ff.run_finished, seg_length,
                        rsp_ff.right_wheel_speed, rsp_ff.left_wheel_speed};
   assign rsp_tuser  = {rsp_ff.segment_kind, rsp_ff.segment_valid};

   a_ready_with_room: assert property (@(posedge clock) disable iff (reset)
      !(v1_ff && v2_ff && rsp_valid_ff) |-> req_tready)
      else $error("input stalled with a free pipeline stage");

   a_idle_length_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.segment_valid) |-> (seg_length == '0))
      else $error("segment length reported without a segment");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.segment_valid) |->
         (rsp_ff.segment_kind == wfdc_pkg::SEG_LEFT_TURN ||
          rsp_ff.segment_kind == wfdc_pkg::SEG_RIGHT_TURN ||
          rsp_ff.segment_kind == wfdc_pkg::SEG_STOP))
      else $error("illegal segment kind");

   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_ff.left_wheel_speed <= wfdc_pkg::WHEEL_LIMIT &&
          rsp_ff.left_wheel_speed >= -wfdc_pkg::WHEEL_LIMIT &&
          rsp_ff.right_wheel_speed <= wfdc_pkg::WHEEL_LIMIT &&
          rsp_ff.right_wheel_speed >= -wfdc_pkg::WHEEL_LIMIT))
      else $error("wheel command outside the clamp range");

endmodule

[tb/sv/wall_following_drive_controller_test.sv]
// ----------------------------------------------------------------------------
// wall_following_drive_controller_test: self-checking bench of the drive controller
// Takes the controller through its calibration once, then many follow, left-turn
// and right-turn sequences under several register settings, with random gaps
// and stalls on both streams. Every result beat is checked against a
// cycle-free predictor of the sequencer.
// ----------------------------------------------------------------------------
module wall_following_drive_controller_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int REQ_BITS    = wfdc_pkg::REQ_TDATA_BITS;

   typedef enum logic [3:0] {
      SEQ_FWD, SEQ_CAL_LOW, SEQ_CAL_RISE, SEQ_PEAK, SEQ_ALIGN,
      SEQ_FOLLOW, SEQ_LEFT_TURN, SEQ_LEFT_RECOVER, SEQ_RIGHT_TURN
   } seq_state_type;

   typedef struct {
      logic                                stop;
      logic                                bump_l;
      logic                                bump_r;
      logic [wfdc_pkg::WALL_BITS-1:0]      wall;
   } tick_type;

   typedef struct {
      logic signed [wfdc_pkg::WHEEL_BITS-1:0] left;
      logic signed [wfdc_pkg::WHEEL_BITS-1:0] right;
      logic                                   seg_valid;
      logic [wfdc_pkg::KIND_BITS-1:0]         seg_kind;
      logic [wfdc_pkg::SEG_LEN_BITS-1:0]      seg_len;
      logic                                   finished;
   } drive_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                                  csr_we = 1'b0;
   logic [wfdc_pkg::CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [wfdc_pkg::CSR_DATA_BITS-1:0]    csr_wdata = '0;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [wfdc_pkg::REQ_TDATA_BITS-1:0]   req_tdata = '0;
   logic                                  req_tlast = 1'b0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [wfdc_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic [wfdc_pkg::RSP_TUSER_BITS-1:0]   rsp_tuser;

   wall_following_drive_controller dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of registers and sequencer state
   logic [wfdc_pkg::SPEED_BITS-1:0]  cfg_cruise = wfdc_pkg::CRUISE_SPEED_RESET;
   logic [wfdc_pkg::SPEED_BITS-1:0]  cfg_spin   = wfdc_pkg::SPIN_SPEED_RESET;
   logic [wfdc_pkg::TICK_BITS-1:0]   cfg_tick   = wfdc_pkg::TICK_MS_RESET;
   seq_state_type          seq_state  = SEQ_FWD;
   int                     wall_tgt   = int'(wfdc_pkg::WALL_TARGET_RESET);
   int unsigned            phase_ms   = 0;
   longint unsigned        seg_ms     = 0;
   int                     rt_step    = 0;
   int                     left_cmd   = 0;
   int                     right_cmd  = 0;
   bit                     done       = 1'b0;

   tick_type  tick_q[$];
   drive_type drive_q[$];
   int     ticks_queued = 0;
   int     n_errors = 0;
   int     cycles = 0;
   bit     no_gaps = 1'b0;
   bit     beat_taken = 1'b0;
   int     send_gap = 0;
   int     hold_cnt = 0;
   int     rsp_cycles = 0;

   function automatic int wheel_limit(int v);
      if (v > 500) return 500;
      if (v < -500) return -500;
      return v;
   endfunction

   function automatic logic [wfdc_pkg::SEG_LEN_BITS-1:0] segment_length();
      longint unsigned v;
      v = seg_ms * longint'(cfg_cruise) / 8000;
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic set_wheels(input int l, input int r);
      left_cmd  = wheel_limit(l);
      right_cmd = wheel_limit(r);
   endtask

   task automatic predict_drive(input tick_type t);
      drive_type d;
      int     cs;
      int     ss;
      int     wall;
      int     diff;
      bit     bump;
      d.seg_valid = 1'b0;
      d.seg_kind  = '0;
      d.seg_len   = '0;
      cs   = int'(cfg_cruise);
      ss   = int'(cfg_spin);
      wall = int'(t.wall);
      bump = t.bump_l | t.bump_r;
      if (done) begin
         set_wheels(0, 0);
      end else begin
         phase_ms = (phase_ms + cfg_tick > 65535) ? 65535 : phase_ms + cfg_tick;
         seg_ms = seg_ms + cfg_tick;
         if (seg_ms > 64'hFFFF_FFFF) seg_ms = 64'hFFFF_FFFF;
         if (t.stop) begin
            d.seg_valid = 1'b1;
            d.seg_kind  = wfdc_pkg::SEG_STOP;
            d.seg_len   = segment_length();
            set_wheels(0, 0);
            done = 1'b1;
         end else begin
            case (seq_state)
               SEQ_FWD: begin
                  if (bump) begin
                     set_wheels(-ss, ss);
                     seq_state = SEQ_CAL_LOW;
                  end else begin
                     set_wheels(cs, cs);
                  end
               end
               SEQ_CAL_LOW: begin
                  if (wall <= 10) seq_state = SEQ_CAL_RISE;
               end
               SEQ_CAL_RISE: begin
                  if (wall >= 20) seq_state = SEQ_PEAK;
               end
               SEQ_PEAK: begin
                  if (wall > wall_tgt) begin
                     wall_tgt = wall;
                  end else if (wall < 5) begin
                     set_wheels(ss, -ss);
                     wall_tgt = wall_tgt / 2;
                     seq_state = SEQ_ALIGN;
                  end
               end
               SEQ_ALIGN: begin
                  if (wall > wall_tgt) begin
                     set_wheels(0, 0);
                     seq_state = SEQ_FOLLOW;
                  end
               end
               SEQ_FOLLOW: begin
                  if (bump) begin
                     d.seg_valid = 1'b1;
                     d.seg_kind  = wfdc_pkg::SEG_LEFT_TURN;
                     d.seg_len   = segment_length();
                     set_wheels(-ss, ss);
                     phase_ms = 0;
                     seq_state = SEQ_LEFT_TURN;
                  end else begin
                     diff = (wall_tgt - wall) / 3;
                     set_wheels(cs + diff, cs - diff);
                     if (wall < 5) begin
                        set_wheels(cs, cs);
                        phase_ms = 0;
                        rt_step = 0;
                        seq_state = SEQ_RIGHT_TURN;
                     end
                  end
               end
               SEQ_LEFT_TURN: begin
                  if (wall > wall_tgt * 3 / 2) begin
                     set_wheels(0, 0);
                     seg_ms = 0;
                     seq_state = SEQ_FOLLOW;
                  end else if (phase_ms > 5000) begin
                     set_wheels(ss, -ss);
                     phase_ms = 0;
                     seq_state = SEQ_LEFT_RECOVER;
                  end
               end
               SEQ_LEFT_RECOVER: begin
                  if (phase_ms >= 2500) begin
                     set_wheels(0, 0);
                     seg_ms = 0;
                     seq_state = SEQ_FOLLOW;
                  end
               end
               SEQ_RIGHT_TURN: begin
                  if ((wall > 5 && rt_step != 1) || bump) begin
                     seq_state = SEQ_FOLLOW;
                  end else if (rt_step == 0 && phase_ms > 2000) begin
                     set_wheels(ss, -ss);
                     phase_ms = 0;
                     d.seg_valid = 1'b1;
                     d.seg_kind  = wfdc_pkg::SEG_RIGHT_TURN;
                     d.seg_len   = segment_length();
                     rt_step = 1;
                  end else if (rt_step == 1 && phase_ms > 2500) begin
                     set_wheels(cs, cs);
                     phase_ms = 0;
                     seg_ms = 0;
                     rt_step = 2;
                  end else if (rt_step == 2 && phase_ms > 2200) begin
                     seq_state = SEQ_FOLLOW;
                  end
               end
               default: seq_state = SEQ_FOLLOW;
            endcase
         end
      end
      d.left     = left_cmd[wfdc_pkg::WHEEL_BITS-1:0];
      d.right    = right_cmd[wfdc_pkg::WHEEL_BITS-1:0];
      d.finished = done;
      drive_q.insert(drive_q.size(), d);
   endtask

   task automatic flag_error(input string msg);
      $display("ERROR at cycle %0d: %s", cycles, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) flag_error($sformatf("%s: got %0d, expected %0d", name, got, want));
   endtask

   // accept side: a beat is taken at a rising edge with tvalid and tready high
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else if (!reset && req_tvalid && req_tready) begin
         predict_drive(tick_q.pop_front());
         beat_taken = 1'b1;
      end
   end

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || beat_taken)) begin
         beat_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (tick_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_BITS'({tick_q[0].wall, tick_q[0].bump_r,
                                     tick_q[0].bump_l});
            req_tlast  <= tick_q[0].stop;
            send_gap = draw_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      int r;
      if (!reset) begin
         rsp_cycles++;
         // hold off long enough to back the block up into its input
         if (rsp_cycles % 1500 == 0) hold_cnt = 80;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else if (no_gaps) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               hold_cnt = (r < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            end
         end
      end
   end

   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (drive_q.size() == 0) begin
            flag_error("result beat with nothing expected");
         end else begin
            want = drive_q.pop_front();
            check_field("left wheel", int'($signed(rsp_tdata[9:0])), int'(want.left));
            check_field("right wheel", int'($signed(rsp_tdata[19:10])),
                        int'(want.right));
            check_field("segment length", int'(rsp_tdata[35:20]), int'(want.seg_len));
            check_field("run finished", int'(rsp_tdata[36]), int'(want.finished));
            check_field("segment valid", int'(rsp_tuser[0]), int'(want.seg_valid));
            check_field("segment kind", int'(rsp_tuser[2:1]), int'(want.seg_kind));
         end
      end
   end

   task automatic push_tick(input int stp, input int bl, input int br, input int wall);
      tick_type t;
      t.stop   = stp[0];
      t.bump_l = bl[0];
      t.bump_r = br[0];
      t.wall   = wall[wfdc_pkg::WALL_BITS-1:0];
      tick_q.insert(tick_q.size(), t);
      ticks_queued++;
   endtask

   task automatic write_reg(input logic [wfdc_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [wfdc_pkg::CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         wfdc_pkg::CSR_CRUISE_SPEED: cfg_cruise = val[wfdc_pkg::SPEED_BITS-1:0];
         wfdc_pkg::CSR_SPIN_SPEED:   cfg_spin   = val[wfdc_pkg::SPEED_BITS-1:0];
         wfdc_pkg::CSR_TICK_MS:      cfg_tick   = val[wfdc_pkg::TICK_BITS-1:0];
         wfdc_pkg::CSR_INITIAL_WALL_TARGET: begin
            if (seq_state < SEQ_PEAK) wall_tgt = int'(val);
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (tick_q.size() != 0 || drive_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic int ticks_for(int ms);
      int n;
      if (cfg_tick == 0) return 30;
      n = ms / int'(cfg_tick) + 2;
      return (n > 90) ? 90 : n;
   endfunction

   // well-formed follow, left-turn and right-turn sequences, plus some noise
   task automatic queue_traffic(input int count);
      int goal;
      int pick;
      int n;
      int hi;
      int wall;
      bit [1:0] bumps;
      goal = ticks_queued + count;
      while (ticks_queued < goal) begin
         pick = $urandom_range(0, 99);
         hi = wall_tgt * 3 / 2;
         if (pick < 40) begin
            n = $urandom_range(4, 24);
            repeat (n) begin
               if ($urandom_range(0, 4) != 0) wall = wall_tgt + $urandom_range(0, 600) - 300;
               else wall = $urandom_range(5, 4095);
               if (wall < 5) wall = 5;
               if (wall > 4095) wall = 4095;
               push_tick(0, 0, 0, wall);
            end
         end else if (pick < 60) begin
            bumps = 2'($urandom_range(1, 3));
            push_tick(0, int'(bumps[0]), int'(bumps[1]), $urandom_range(5, 4095));
            if (hi < 4095 && $urandom_range(0, 1)) begin
               repeat ($urandom_range(0, 6))
                  push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, hi));
               push_tick(0, 0, 0, $urandom_range(hi + 1, 4095));
            end else begin
               if (hi > 4095) hi = 4095;
               repeat (ticks_for(5000))
                  push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, hi));
               repeat (ticks_for(2500))
                  push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 4095));
            end
         end else if (pick < 82) begin
            push_tick(0, 0, 0, $urandom_range(0, 4));
            repeat (ticks_for(6700)) begin
               if ($urandom_range(0, 14) == 0)
                  push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 4095));
               else
                  push_tick(0, 0, 0, $urandom_range(0, 5));
            end
         end else begin
            push_tick(0, $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 4095));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(wfdc_pkg::CSR_CRUISE_SPEED, 12'd200);
      write_reg(wfdc_pkg::CSR_SPIN_SPEED, 12'hFFF);
      write_reg(wfdc_pkg::CSR_TICK_MS, 12'd100);
      write_reg(wfdc_pkg::CSR_INITIAL_WALL_TARGET, 12'd30);

      // forward drive, bump, then the low and rising halves of calibration
      push_tick(0, 0, 0, 4095);
      push_tick(0, 0, 0, 0);
      push_tick(0, 0, 1, 7);
      push_tick(0, 1, 1, 11);
      push_tick(0, 0, 0, 10);
      push_tick(0, 0, 0, 19);
      wait_drained();
      // target write before peak tracking reloads the working target
      write_reg(wfdc_pkg::CSR_INITIAL_WALL_TARGET, 12'd60);
      push_tick(0, 0, 0, 20);
      push_tick(0, 0, 0, 60);
      push_tick(0, 0, 0, 1000);
      push_tick(0, 0, 0, 5);
      push_tick(0, 0, 0, 4);
      push_tick(0, 0, 0, 500);
      push_tick(0, 0, 0, 501);
      push_tick(0, 0, 0, 4095);
      push_tick(0, 0, 0, 200);
      push_tick(0, 0, 0, 3);
      push_tick(0, 1, 0, 0);
      push_tick(0, 1, 1, 500);
      push_tick(0, 0, 0, 750);
      push_tick(0, 0, 0, 751);
      wait_drained();

      write_reg(wfdc_pkg::CSR_INITIAL_WALL_TARGET, 12'hFFF);
      write_reg(wfdc_pkg::CSR_CRUISE_SPEED, 12'd150);
      write_reg(wfdc_pkg::CSR_SPIN_SPEED, 12'd80);
      queue_traffic(250);
      wait_drained();

      write_reg(wfdc_pkg::CSR_CRUISE_SPEED, 12'hFFF);
      write_reg(wfdc_pkg::CSR_SPIN_SPEED, 12'd0);
      write_reg(wfdc_pkg::CSR_TICK_MS, 12'd127);
      no_gaps = 1'b1;
      queue_traffic(200);
      wait_drained();
      no_gaps = 1'b0;

      write_reg(wfdc_pkg::CSR_CRUISE_SPEED, 12'd0);
      write_reg(wfdc_pkg::CSR_SPIN_SPEED, 12'd500);
      write_reg(wfdc_pkg::CSR_TICK_MS, 12'd1);
      write_reg(wfdc_pkg::CSR_INITIAL_WALL_TARGET, 12'd0);
      queue_traffic(150);
      wait_drained();

      write_reg(wfdc_pkg::CSR_CRUISE_SPEED, 12'd500);
      write_reg(wfdc_pkg::CSR_SPIN_SPEED, 12'd511);
      write_reg(wfdc_pkg::CSR_TICK_MS, 12'd0);
      queue_traffic(100);
      wait_drained();

      write_reg(wfdc_pkg::CSR_CRUISE_SPEED, 12'd333);
      write_reg(wfdc_pkg::CSR_SPIN_SPEED, 12'd250);
      write_reg(wfdc_pkg::CSR_TICK_MS, 12'd64);
      queue_traffic(250);

      // stop, then ticks that the finished block must answer with idle results
      push_tick(1, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 4095));
      repeat (10)
         push_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 4095));
      wait_drained();
      repeat (8) @(negedge clock);

      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[wall_following_drive_controller.f]
hw/rtl/wfdc_pkg.sv
hw/rtl/wfdc_ctrl.sv
hw/rtl/wfdc_seglen.sv
hw/rtl/wall_following_drive_controller.sv
tb/sv/wall_following_drive_controller_test.sv
